@@ src/lst_pkg.sv @@
`timescale 1ns / 1ps
package lst_pkg;
    localparam int MAX_JOBS = 8;
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TOT_W = 16 + CNT_W;
    localparam int QDEPTH = 2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] job_id;
        logic [15:0] job_length;
        logic [15:0] job_tickets;
        logic [30:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] winner_id;
        logic [15:0] winner_remaining;
        logic [15:0] winner_tickets_left;
        logic        finished;
        logic [3:0]  job_count;
        logic [18:0] ticket_total;
    } out_item_t;
endpackage

@@ src/lst_queue.sv @@
`timescale 1ns / 1ps
module lst_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  lst_pkg::in_item_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output lst_pkg::in_item_t rd_data
);
    import lst_pkg::*;

    in_item_t mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH+1)-1:0] cnt_reg;
    logic push, pop;

    assign wr_ready = (cnt_reg != QDEPTH[$clog2(QDEPTH+1)-1:0]);
    assign rd_valid = (cnt_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    // store and advance pointers
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

@@ src/lst_engine.sv @@
`timescale 1ns / 1ps
module lst_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        slice_len,
    input  logic               in_valid,
    output logic               in_ready,
    input  lst_pkg::in_item_t  in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lst_pkg::out_item_t m_data
);
    import lst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [15:0] id_reg [MAX_JOBS];
    logic [15:0] len_reg [MAX_JOBS];
    logic [15:0] tk_reg [MAX_JOBS];
    logic [CNT_W-1:0] count_reg;
    logic [TOT_W-1:0] total_reg;
    logic [2:0] state_reg;
    logic [4:0] bit_reg;
    logic [30:0] rnd_reg;
    logic [TOT_W-1:0] rem_reg;
    logic [CNT_W-1:0] idx_reg;
    out_item_t res_reg;
    out_item_t res_next;
    logic res_valid_reg;
    logic [TOT_W:0] trial;
    logic [16:0] r_len;
    logic [15:0] cur_tk;
    logic [15:0] tk_m1;
    logic rm;

    assign in_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign m_valid = res_valid_reg;
    assign m_data = res_reg;
    assign trial = {rem_reg, rnd_reg[30]} - {1'b0, total_reg};
    assign cur_tk = tk_reg[idx_reg[IDX_W-1:0]];
    assign tk_m1 = cur_tk - 16'd1;
    assign r_len = {1'b0, len_reg[idx_reg[IDX_W-1:0]]} - {1'b0, slice_len};
    // removal when signed remainder is below one slice or zero
    assign rm = r_len[16] || (r_len[15:0] < slice_len) || (r_len[15:0] == 16'd0);

    // build the result fields for the current state
    always_comb begin
        res_next = res_reg;
        case (state_reg)
            S_IDLE: begin
                res_next = '0;
                if (in_data.action == ACT_ADD) begin
                    if (count_reg >= MAX_JOBS[CNT_W-1:0]) begin
                        res_next.status = ST_FULL;
                        res_next.job_count = 4'(count_reg);
                        res_next.ticket_total = 19'(total_reg);
                    end else begin
                        res_next.status = ST_OK;
                        res_next.job_count = 4'(count_reg + 1'b1);
                        res_next.ticket_total =
                            19'(total_reg + TOT_W'(in_data.job_tickets));
                    end
                end else begin
                    res_next.status = ST_EMPTY;
                    res_next.job_count = 4'(count_reg);
                    res_next.ticket_total = 19'(total_reg);
                end
            end
            S_WALK: begin
                res_next.status = ST_OK;
                res_next.winner_id = id_reg[idx_reg[IDX_W-1:0]];
                res_next.winner_tickets_left = tk_m1;
                res_next.finished = rm;
                res_next.winner_remaining = rm ? 16'd0 : r_len[15:0];
            end
            S_OUT: begin
                res_next.job_count = 4'(count_reg);
                res_next.ticket_total = 19'(total_reg);
            end
            default: res_next = res_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        if (in_data.action == ACT_ADD) begin
                            if (count_reg < MAX_JOBS[CNT_W-1:0]) begin
                                id_reg[count_reg[IDX_W-1:0]] <= in_data.job_id;
                                len_reg[count_reg[IDX_W-1:0]] <= in_data.job_length;
                                tk_reg[count_reg[IDX_W-1:0]] <= in_data.job_tickets;
                                count_reg <= count_reg + 1'b1;
                                total_reg <= total_reg + TOT_W'(in_data.job_tickets);
                            end
                            res_reg <= res_next;
                            res_valid_reg <= 1'b1;
                        end else if (count_reg == '0 || total_reg == '0) begin
                            res_reg <= res_next;
                            res_valid_reg <= 1'b1;
                        end else begin
                            rnd_reg <= in_data.random_value;
                            rem_reg <= '0;
                            bit_reg <= 5'd0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    if (!trial[TOT_W]) rem_reg <= trial[TOT_W-1:0];
                    else rem_reg <= {rem_reg[TOT_W-2:0], rnd_reg[30]};
                    rnd_reg <= {rnd_reg[29:0], 1'b0};
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd30) begin
                        idx_reg <= '0;
                        state_reg <= S_WALK;
                    end
                end
                // rem_reg holds ticket-1; walk cumulative tickets
                S_WALK: begin
                    if (rem_reg < TOT_W'(cur_tk)) begin
                        res_reg <= res_next;
                        if (rm) begin
                            total_reg <= total_reg - TOT_W'(cur_tk);
                            state_reg <= S_SHIFT;
                        end else begin
                            len_reg[idx_reg[IDX_W-1:0]] <= r_len[15:0];
                            tk_reg[idx_reg[IDX_W-1:0]] <= tk_m1;
                            total_reg <= total_reg - 1'b1;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        rem_reg <= rem_reg - TOT_W'(cur_tk);
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // shift later entries down one
                S_SHIFT: begin
                    if (idx_reg + 1'b1 < count_reg) begin
                        id_reg[idx_reg[IDX_W-1:0]] <= id_reg[IDX_W'(idx_reg + 1'b1)];
                        len_reg[idx_reg[IDX_W-1:0]] <= len_reg[IDX_W'(idx_reg + 1'b1)];
                        tk_reg[idx_reg[IDX_W-1:0]] <= tk_reg[IDX_W'(idx_reg + 1'b1)];
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    res_reg <= res_next;
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_JOBS[CNT_W-1:0]) else $error("count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (idx_reg < count_reg)) else $error("walk overrun");
`endif
endmodule

@@ src/lottery_scheduler_table.sv @@
`timescale 1ns / 1ps
// Items are registered in the queue before the engine. Add, full add and empty draw
// results are registered from the idle state; a draw runs a modulo step per bit of
// random_value, a walk step per entry up to the winner, a shift step per entry from
// a removed winner to the end, then S_OUT. One item is in the engine at a time,
// the next taken the cycle after the result is taken; a 2-entry queue holds items.
// Reset: synchronous active-low aresetn empties table, queue and total; slice is 5.
module lottery_scheduler_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  lst_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lst_pkg::out_item_t m_data
);
    import lst_pkg::*;

    logic [15:0] slice_reg;
    logic q_valid, q_ready;
    in_item_t q_data;

    // hold time slice
    always_ff @(posedge aclk) begin
        if (!aresetn) slice_reg <= 16'd5;
        else if (cfg_we) slice_reg <= cfg_wdata;
    end

    lst_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(s_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    lst_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .slice_len(slice_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
